>>> rtl/pliu_pkg.sv
package pliu_pkg;

    localparam int OP_W    = 2;
    localparam int POS_W   = 8;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int OCNT_W  = 5;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] item_value;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [VAL_W-1:0] read_value;
        logic [OCNT_W-1:0]       entry_count;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic shift_in;
        logic shift_out;
        logic read_hit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic pos_valid;
    } flags_t;

endpackage

>>> rtl/pliu_ctrl.sv
module pliu_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [pliu_pkg::OP_W-1:0]  op,
    output logic                       m_valid,
    input  logic                       m_ready,
    input  pliu_pkg::flags_t           flags,
    output pliu_pkg::cmd_t             cmd,
    output logic [pliu_pkg::STAT_W-1:0] status
);
    import pliu_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_HOLD = 1'b1;

    logic              state_reg, state_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic              accept;
    logic              ok;

    assign s_ready = (state_reg == S_IDLE) || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = (state_reg == S_HOLD);
    assign status  = status_reg;

    always_comb begin
        ok = 1'b0;
        status_next = ST_BADPOS;
        case (op)
            OP_INSERT: begin
                ok = !flags.full;
                status_next = flags.full ? ST_FULL : ST_DONE;
            end
            OP_ERASE, OP_READ: begin
                ok = flags.pos_valid;
                status_next = flags.pos_valid ? ST_DONE : ST_BADPOS;
            end
            default: begin
                ok = 1'b0;
                status_next = ST_BADPOS;
            end
        endcase
    end

    always_comb begin
        cmd.load      = accept;
        cmd.shift_in  = accept && ok && (op == OP_INSERT);
        cmd.shift_out = accept && ok && (op == OP_ERASE);
        cmd.read_hit  = ok && (op == OP_READ);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) state_next = S_HOLD;
            end
            S_HOLD: begin
                if (accept) state_next = S_HOLD;
                else if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
        end
    end

endmodule

>>> rtl/pliu_dpath.sv
module pliu_dpath #(
    parameter int CAPACITY = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [pliu_pkg::POS_W-1:0]         position,
    input  logic signed [pliu_pkg::VAL_W-1:0]  item_value,
    input  pliu_pkg::cmd_t                     cmd,
    output pliu_pkg::flags_t                   flags,
    output logic signed [pliu_pkg::VAL_W-1:0]  read_value,
    output logic [pliu_pkg::OCNT_W-1:0]        entry_count
);
    import pliu_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic signed [VAL_W-1:0] entries_reg [CAPACITY];
    logic [CNT_W-1:0]        count_reg;
    logic signed [VAL_W-1:0] read_value_reg;

    logic [CMP_W-1:0] pos_ext, cnt_ext, ins_pos;
    logic [IDX_W-1:0] rd_idx;

    assign pos_ext = CMP_W'(position);
    assign cnt_ext = CMP_W'(count_reg);
    // an insert past the end appends
    assign ins_pos = (pos_ext > cnt_ext) ? cnt_ext : pos_ext;
    assign rd_idx  = pos_ext[IDX_W-1:0];

    assign flags.full      = (count_reg == CNT_W'(CAPACITY));
    assign flags.pos_valid = (pos_ext < cnt_ext);

    // cell chain: each cell takes its left or right neighbour, or the new value at the insert point
    always_ff @(posedge aclk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (cmd.shift_in) begin
                if (CMP_W'(i) == ins_pos) entries_reg[i] <= item_value;
                else if (i > 0 && CMP_W'(i) > ins_pos) entries_reg[i] <= entries_reg[(i > 0) ? i - 1 : 0];
            end else if (cmd.shift_out) begin
                if (i < CAPACITY - 1 && CMP_W'(i) >= pos_ext)
                    entries_reg[i] <= entries_reg[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.shift_in) begin
            count_reg <= count_reg + CNT_W'(1);
        end else if (cmd.shift_out) begin
            count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            read_value_reg <= cmd.read_hit ? entries_reg[rd_idx] : '0;
        end
    end

    assign read_value  = read_value_reg;
    assign entry_count = OCNT_W'(count_reg);

endmodule

>>> rtl/positional_list_insert_erase_unit.sv
// a result is registered and is valid in the cycle after its word is accepted
// throughput: one word per cycle while results are taken at once
// the whole cell chain shifts in parallel on insert or erase; read is one mux
// reset: synchronous active-low aresetn clears the count and the handshake,
// cell contents stay undefined until written
module positional_list_insert_erase_unit #(
    parameter int CAPACITY = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pliu_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pliu_pkg::out_item_t  m_data
);
    import pliu_pkg::*;

    cmd_t              cmd;
    flags_t            flags;
    logic [STAT_W-1:0] status;
    logic signed [VAL_W-1:0] read_value;
    logic [OCNT_W-1:0] entry_count;

    pliu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .op      (s_data.op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .flags   (flags),
        .cmd     (cmd),
        .status  (status)
    );

    pliu_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .position    (s_data.position),
        .item_value  (s_data.item_value),
        .cmd         (cmd),
        .flags       (flags),
        .read_value  (read_value),
        .entry_count (entry_count)
    );

    always_comb begin
        m_data.status      = status;
        m_data.read_value  = read_value;
        m_data.entry_count = entry_count;
    end

endmodule

>>> tb/positional_list_insert_erase_unit_tb.sv
`timescale 1ns / 1ps

module positional_list_insert_erase_unit_tb;
    import pliu_pkg::*;

    localparam int CAPACITY = 16;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 450;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    positional_list_insert_erase_unit #(
        .CAPACITY(CAPACITY)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // shadow copy of the sequence, entry 0 is the front
    logic signed [VAL_W-1:0] list_vals [CAPACITY];
    int                      list_len;
    out_item_t               expected_results [$];

    int error_count;
    int words_sent;
    int results_checked;
    int full_refusals;
    int badpos_refusals;
    int reads_done;
    int peak_len;
    int burst_left;
    int ready_mode;
    int ready_tick;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // applies one operation to the shadow list and returns the result it gives
    function automatic out_item_t apply_list_op(in_item_t w);
        out_item_t r;
        int        p;
        r.status     = ST_DONE;
        r.read_value = '0;
        p            = w.position;
        case (w.op)
            OP_INSERT: begin
                if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    if (p > list_len) p = list_len;
                    for (int i = list_len; i > p; i--) list_vals[i] = list_vals[i-1];
                    list_vals[p] = w.item_value;
                    list_len++;
                end
            end
            OP_ERASE: begin
                if (p >= list_len) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (int i = p; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
                    list_len--;
                end
            end
            OP_READ: begin
                if (p >= list_len) r.status = ST_BADPOS;
                else r.read_value = list_vals[p];
            end
            default: r.status = ST_BADPOS;
        endcase
        r.entry_count = OCNT_W'(list_len);
        return r;
    endfunction

    // drives one word, waits for the handshake, then either keeps valid up or takes a gap
    task automatic send_word(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic signed [VAL_W-1:0] val);
        in_item_t  w;
        out_item_t exp_r;
        int        gap;
        w.op         = op;
        w.position   = pos;
        w.item_value = val;
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        exp_r = apply_list_op(w);
        expected_results = {expected_results, exp_r};
        if (op == OP_READ && exp_r.status == ST_DONE) reads_done++;
        words_sent++;
        if (list_len > peak_len) peak_len = list_len;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge aclk);
            // now and then a long stretch without gaps
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 10);
        end
    endtask

    task automatic test_empty_list();
        send_word(OP_READ, 8'd0, 32'sd0);
        send_word(OP_ERASE, 8'd255, 32'sd0);
        send_word(OP_UNUSED, 8'd0, 32'sd7);
        send_word(OP_INSERT, 8'd255, 32'sh5555_5555);
    endtask

    task automatic test_fill_and_overflow();
        send_word(OP_INSERT, 8'd0, 32'sh7fff_ffff);
        send_word(OP_INSERT, 8'd255, 32'sh8000_0000);
        send_word(OP_INSERT, 8'd1, 32'sd0);
        send_word(OP_INSERT, 8'd0, -32'sd1);
        send_word(OP_INSERT, 8'd3, 32'shaaaa_aaaa);
        for (int i = 0; i < CAPACITY - 5; i++) begin
            send_word(OP_INSERT, POS_W'($urandom_range(0, list_len + 1)), $urandom);
        end
        // list is full here, insert must be refused
        send_word(OP_INSERT, 8'd2, 32'sd1234);
    endtask

    task automatic test_read_erase_edges();
        send_word(OP_READ, 8'd15, 32'sd0);
        send_word(OP_READ, 8'd16, 32'sd0);
        send_word(OP_ERASE, 8'd0, 32'sd0);
        send_word(OP_ERASE, 8'd14, 32'sd0);
    endtask

    task automatic test_random_traffic();
        int                      insert_weight;
        int                      pick;
        logic [OP_W-1:0]         op;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
        insert_weight = 45;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // alternate filling, draining and balanced phases so full and empty both recur
            if (n % 30 == 0) begin
                case ($urandom_range(0, 2))
                    0:       insert_weight = 75;
                    1:       insert_weight = 15;
                    default: insert_weight = 45;
                endcase
            end
            pick = $urandom_range(0, 99);
            if (pick < 3) op = OP_UNUSED;
            else if (pick < 3 + insert_weight) op = OP_INSERT;
            else if (pick % 2 == 0) op = OP_ERASE;
            else op = OP_READ;
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
                if (op == OP_INSERT || list_len == 0) pos = POS_W'($urandom_range(0, list_len));
                else pos = POS_W'($urandom_range(0, list_len - 1));
            end else if (pick == 8) begin
                pos = POS_W'(list_len);
            end else begin
                pos = POS_W'($urandom_range(0, 255));
            end
            case ($urandom_range(0, 11))
                0:       val = 32'sh7fff_ffff;
                1:       val = 32'sh8000_0000;
                2:       val = -32'sd1;
                3:       val = 32'sd0;
                default: val = $urandom;
            endcase
            send_word(op, pos, val);
        end
    endtask

    // receiver readiness follows a randomly redrawn mode: always ready, ready half the time, or rarely ready
    always @(posedge aclk) begin
        ready_tick++;
        if (ready_tick % 50 == 0) ready_mode = $urandom_range(0, 2);
        case (ready_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 1) == 1);
            default: m_ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result word with nothing expected: status %0d count %0d",
                       m_data.status, m_data.entry_count);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (m_data.status != want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_data.status);
                    error_count++;
                end
                if (m_data.read_value != want.read_value) begin
                    $error("read_value: expected %0d, got %0d", want.read_value,
                           m_data.read_value);
                    error_count++;
                end
                if (m_data.entry_count != want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d", want.entry_count,
                           m_data.entry_count);
                    error_count++;
                end
                if (want.status == ST_FULL) full_refusals++;
                if (want.status == ST_BADPOS) badpos_refusals++;
            end
        end
    end

    initial begin
        int drain_wait;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        list_len    = 0;
        error_count = 0;
        words_sent  = 0;
        results_checked = 0;
        full_refusals   = 0;
        badpos_refusals = 0;
        reads_done  = 0;
        peak_len    = 0;
        burst_left  = 0;
        ready_mode  = 0;
        ready_tick  = 0;
        drain_wait  = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_list();
        test_fill_and_overflow();
        test_read_erase_edges();
        test_random_traffic();
        s_valid <= 1'b0;

        while (expected_results.size() != 0 && drain_wait < 2000) begin
            @(posedge aclk);
            drain_wait++;
        end
        repeat (4) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            error_count++;
        end

        $display("ran %0d words through the list, %0d results checked, peak occupancy %0d",
                 words_sent, results_checked, peak_len);
        $display("refusals seen: %0d on a full list, %0d on a bad position or op; %0d reads",
                 full_refusals, badpos_refusals, reads_done);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/pliu_pkg.sv
rtl/pliu_ctrl.sv
rtl/pliu_dpath.sv
rtl/positional_list_insert_erase_unit.sv
tb/positional_list_insert_erase_unit_tb.sv
